// ----- hw/rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants for the positional list
// Sizes of the cell chain, index widths and the control struct that is
// broadcast from the sequencer to every cell.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 8;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;
   localparam int GROUP      = 8;
   localparam int NGROUPS    = (CAPACITY + GROUP - 1) / GROUP;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] idx;
   } ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SELECT = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

endpackage

// ----- hw/rtl/pli_cell.sv -----
// ----------------------------------------------------------------------------
// pli_cell: one list entry
// Holds one value and shifts it towards the tail on insert or towards the
// head on delete, deciding locally from its own position in the chain.
// ----------------------------------------------------------------------------
module pli_cell
   import pli_pkg::*;
(
   input  logic              clock,
   input  ctrl_type          ctrl,
   input  logic [IDX_W-1:0]  cell_index,
   input  logic [DATA_W-1:0] new_value,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data,
   output logic [DATA_W-1:0] hit_data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (cell_index > ctrl.idx) begin
            data_in = left_data;
         end else if (cell_index == ctrl.idx) begin
            data_in = new_value;
         end
      end else if (ctrl.del) begin
         if (cell_index >= ctrl.idx) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign hit_data = (cell_index == ctrl.idx) ? data_ff : '0;

endmodule

// ----- hw/rtl/pli_gather.sv -----
// ----------------------------------------------------------------------------
// pli_gather: removed-value collection
// Registers per-group OR reductions of the cell hit outputs, then combines
// the group registers for the result register.
// ----------------------------------------------------------------------------
module pli_gather
   import pli_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [DATA_W-1:0] hits [CAPACITY],
   output logic [DATA_W-1:0] gathered
);

   logic [DATA_W-1:0] group_ff [NGROUPS];
   logic [DATA_W-1:0] group_in [NGROUPS];

   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < CAPACITY) begin
               group_in[g] = group_in[g] | hits[g * GROUP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < NGROUPS; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   always_comb begin
      gathered = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         gathered = gathered | group_ff[g];
      end
   end

endmodule

// ----- hw/rtl/positional_list_insert_delete.sv -----
// A new request is accepted only while idle or in the cycle the pending result
// is taken; the removed value passes through the registered per-group gather
// over the cells and then through the result register.
// Reset: synchronous, active high; clears the entry count and the sequencer.
// Cell contents are not reset and are never read before being written.
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with positional insert/delete
// A chain of cells holds the list; the top level clamps positions, checks
// bounds, drives the chain and returns status, removed value and length.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
   import pli_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_status,
   output logic signed [DATA_W-1:0] rsp_removed_value,
   output logic [CNT_W-1:0]         rsp_length
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              status_ff, status_in;
   logic              del_ok_ff, del_ok_in;
   logic [DATA_W-1:0] removed_ff, removed_in;

   logic              accept;
   logic [IDX_W-1:0]  pos_ext, cnt_ext, ins_idx, del_idx;
   logic              ins_err, del_err;
   ctrl_type          ctrl;

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_hits [CAPACITY];
   logic [DATA_W-1:0] gathered;

   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign pos_ext = IDX_W'(req_position);
   assign cnt_ext = IDX_W'(count_ff);
   assign ins_idx = (pos_ext < cnt_ext) ? pos_ext : cnt_ext;
   assign del_idx = (pos_ext == '0) ? '0 : pos_ext - IDX_W'(1);
   assign ins_err = (cnt_ext >= IDX_W'(CAPACITY));
   assign del_err = (del_idx >= cnt_ext);

   always_comb begin
      ctrl.ins = accept && (req_func == FUNC_INSERT) && !ins_err;
      ctrl.del = accept && (req_func == FUNC_DELETE) && !del_err;
      ctrl.idx = (req_func == FUNC_INSERT) ? ins_idx : del_idx;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      pli_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .new_value  (req_value),
         .left_data  ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1]),
         .right_data ((i == CAPACITY - 1) ? '0
                      : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
         .data       (cell_data[i]),
         .hit_data   (cell_hits[i])
      );
   end

   pli_gather u_gather (
      .clock    (clock),
      .load     (ctrl.del),
      .hits     (cell_hits),
      .gathered (gathered)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      del_ok_in  = del_ok_ff;
      removed_in = removed_ff;
      if (accept) begin
         state_in  = ST_SELECT;
         del_ok_in = ctrl.del;
         if (ctrl.ins) begin
            count_in  = count_ff + CNT_W'(1);
            status_in = STATUS_OK;
         end else if (ctrl.del) begin
            count_in  = count_ff - CNT_W'(1);
            status_in = STATUS_OK;
         end else begin
            status_in = STATUS_ERR;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               state_in = ST_IDLE;
            end
            ST_SELECT: begin
               removed_in = del_ok_ff ? gathered : '0;
               state_in   = ST_DONE;
            end
            ST_DONE: begin
               if (rsp_ready) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      status_ff  <= status_in;
      del_ok_ff  <= del_ok_in;
      removed_ff <= removed_in;
   end

   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_length        = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_select: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SELECT))
      else $error("accepted transaction did not enter select");

   a_full_insert_err: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_INSERT) && ins_err) |=> (status_ff == STATUS_ERR)
         && $stable(count_ff))
      else $error("insert into full list not rejected");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_ERR)) |-> (rsp_removed_value == '0))
      else $error("error result carries a removed value");
`endif

endmodule
